/* src/gmmwf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmmwf_pkg
// Shared constants, register indexes and the extreme-pick helper of the
// grayscale min/max window filter.
// ----------------------------------------------------------------------------
package gmmwf_pkg;

  // frame limits and line store geometry
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned MAX_KERNEL = 7;
  localparam int unsigned HALF_MAX   = (MAX_KERNEL - 1) / 2;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 10;
  localparam int unsigned WSZ_W  = 3;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W = $clog2(MAX_KERNEL);
  localparam int unsigned HALF_W = $clog2(HALF_MAX + 1);
  localparam int unsigned SPAN_W = $clog2(MAX_KERNEL);
  localparam int unsigned MEM_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);
  localparam int unsigned POS_W  = $clog2((MAX_HEIGHT + MAX_KERNEL) * MAX_WIDTH);
  localparam int unsigned LAG_W  = $clog2(HALF_MAX * MAX_WIDTH + HALF_MAX + 2) + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd3;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  // keeps the larger (max mode) or smaller (min mode) of two pixels
  function automatic logic [PIX_W-1:0] pick_ext(input logic mode,
                                                input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] res;
    res = a;
    if (mode == MODE_MAX) begin
      if (b > a) res = b;
    end else begin
      if (b < a) res = b;
    end
    return res;
  endfunction

endpackage

/* src/grey_min_max_window_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grey_min_max_window_filter_core
// Streaming 2-D grayscale max/min filter over a centred square window, with
// border pixels copied, built around a single-port line store, one
// compare that folds each column and a compare tree over the column extremes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  s_axis   | in        | s_axis_tvalid/tready      | tdata: pixel_in, tuser: drain
//  m_axis   | out       | m_axis_tvalid/tready      | tdata: pixel_out, tlast: frame_last
//  cfg      | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
//  each request makes n line store reads between accept and ready:
//  1 for a border pixel, 2h+1 inside a row (one new column extreme,
//  the rest held in registers), (2h+1)^2 at the first inside pixel of a row;
//  a request that yields no result makes none. the line store is
//  single-port, one access per cycle.
//  reset clears positions and loads register defaults; the line store is
//  not cleared. a result waiting on m_axis does not stop the next request from being accepted, but holds it in S_OUT.
// ----------------------------------------------------------------------------
module grey_min_max_window_filter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [gmmwf_pkg::PIX_W-1:0]          s_axis_tdata_i,   // [7:0] pixel_in
  input  logic                                 s_axis_tuser_i,   // [0] drain
  // master stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [gmmwf_pkg::PIX_W-1:0]          m_axis_tdata_o,   // [7:0] pixel_out
  output logic                                 m_axis_tlast_o,   // frame_last
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [gmmwf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmmwf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned PIX_W  = gmmwf_pkg::PIX_W;
  localparam int unsigned DIM_W  = gmmwf_pkg::DIM_W;
  localparam int unsigned WSZ_W  = gmmwf_pkg::WSZ_W;
  localparam int unsigned COL_W  = gmmwf_pkg::COL_W;
  localparam int unsigned SLOT_W = gmmwf_pkg::SLOT_W;
  localparam int unsigned HALF_W = gmmwf_pkg::HALF_W;
  localparam int unsigned SPAN_W = gmmwf_pkg::SPAN_W;
  localparam int unsigned ADDR_W = gmmwf_pkg::ADDR_W;
  localparam int unsigned POS_W  = gmmwf_pkg::POS_W;
  localparam int unsigned LAG_W  = gmmwf_pkg::LAG_W;
  localparam int unsigned KERN   = gmmwf_pkg::MAX_KERNEL;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOT,
    S_KPOS,
    S_CHK,
    S_PLAN,
    S_RD,
    S_WAIT,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [DIM_W-1:0] cfg_width_q, cfg_height_q;
  logic [WSZ_W-1:0] cfg_wsize_q;
  logic             cfg_mode_q;

  // positions and their row slots in the line store
  logic [DIM_W-1:0]  in_row_q, in_col_q, out_row_q, out_col_q;
  logic [SLOT_W-1:0] in_slot_q, out_slot_q;

  // per-request registers
  logic [PIX_W-1:0] pix_q;
  logic             drain_q;
  logic [POS_W-1:0] total_q, k_q;
  logic [LAG_W-1:0] lag_q;
  logic             due_q, last_q;

  // read sequencer
  logic [COL_W-1:0]  rd_col_q;
  logic [SLOT_W-1:0] rd_slot_q, base_slot_q;
  logic [SPAN_W-1:0] rd_row_q, row_end_q, cols_left_q, span_q;
  logic              pend_q, pend_first_q, pend_colend_q;

  // column extremes of the current window, newest column in entry 0
  logic [PIX_W-1:0] acc_q;
  logic [PIX_W-1:0] col_ext_q [KERN];
  logic             cache_ok_q;

  // output register
  logic             m_valid_q, m_last_q;
  logic [PIX_W-1:0] m_data_q;

  // line store
  logic [PIX_W-1:0] mem_q [gmmwf_pkg::MEM_DEPTH];
  logic [PIX_W-1:0] mem_rd_q;

  logic [DIM_W-1:0]   w_eff, ht_eff;
  logic [HALF_W-1:0]  half;
  logic [LAG_W-1:0]   lag_c;
  logic [DIM_W-1:0]   kpos_row, kpos_col, mul_a;
  logic [2*DIM_W-1:0] mul_p;
  logic               clr_pos, clr_frame, wr_ok, mem_we, mem_re;
  logic [POS_W-1:0]   k_eff;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               interior, last_c, inc_ok;
  logic [SPAN_W-1:0]  span2h;
  logic [SLOT_W:0]    top_slot;
  logic [DIM_W:0]     in_col_nx, out_col_nx;
  logic [PIX_W-1:0]   acc_next, win_val;

  always_comb begin
    w_eff = cfg_width_q;
    if (cfg_width_q == '0) w_eff = DIM_W'(1);
    if (cfg_width_q > DIM_W'(gmmwf_pkg::MAX_WIDTH)) w_eff = DIM_W'(gmmwf_pkg::MAX_WIDTH);
    ht_eff = cfg_height_q;
    if (cfg_height_q == '0) ht_eff = DIM_W'(1);
    if (cfg_height_q > DIM_W'(gmmwf_pkg::MAX_HEIGHT)) ht_eff = DIM_W'(gmmwf_pkg::MAX_HEIGHT);
    half = HALF_W'(cfg_wsize_q >> 1);
    if ((cfg_wsize_q >> 1) > WSZ_W'(gmmwf_pkg::HALF_MAX)) half = HALF_W'(gmmwf_pkg::HALF_MAX);
    lag_c  = LAG_W'(half * w_eff) + LAG_W'(half);
    span2h = SPAN_W'({half, 1'b0});
  end

  // shared multiplier: frame size first, then the linear input position
  always_comb begin
    clr_pos = (in_col_q >= w_eff) || (out_col_q >= w_eff) || (out_row_q >= ht_eff) ||
              ((LAG_W+1)'(in_row_q) > (LAG_W+1)'(ht_eff) + (LAG_W+1)'(lag_q) + (LAG_W+1)'(1));
    kpos_row = clr_pos ? '0 : in_row_q;
    kpos_col = clr_pos ? '0 : in_col_q;
    mul_a    = (state_q == S_TOT) ? ht_eff : kpos_row;
    mul_p    = (2*DIM_W)'(mul_a) * (2*DIM_W)'(w_eff);
  end

  always_comb begin
    clr_frame = (POS_W+1)'(k_q) >= (POS_W+1)'(total_q) + (POS_W+1)'(lag_q);
    k_eff     = clr_frame ? '0 : k_q;
    wr_ok     = (k_eff < total_q) && !drain_q;
    mem_we    = (state_q == S_CHK) && wr_ok;
    mem_re    = (state_q == S_RD);
    wr_addr   = clr_frame ? '0 : {in_slot_q, in_col_q[COL_W-1:0]};
    rd_addr   = {rd_slot_q, rd_col_q};
  end

  // output position classification
  always_comb begin
    interior = (out_row_q >= DIM_W'(half)) &&
               ((DIM_W+1)'(out_row_q) + (DIM_W+1)'(half) < (DIM_W+1)'(ht_eff)) &&
               (out_col_q >= DIM_W'(half)) &&
               ((DIM_W+1)'(out_col_q) + (DIM_W+1)'(half) < (DIM_W+1)'(w_eff));
    last_c   = (out_row_q == ht_eff - DIM_W'(1)) && (out_col_q == w_eff - DIM_W'(1));
    inc_ok   = cache_ok_q && interior;
    if (out_slot_q >= SLOT_W'(half)) top_slot = (SLOT_W+1)'(out_slot_q) - (SLOT_W+1)'(half);
    else top_slot = (SLOT_W+1)'(out_slot_q) + (SLOT_W+1)'(KERN) - (SLOT_W+1)'(half);
    in_col_nx  = (DIM_W+1)'(in_col_q) + (DIM_W+1)'(1);
    out_col_nx = (DIM_W+1)'(out_col_q) + (DIM_W+1)'(1);
  end

  always_comb begin
    acc_next = pend_first_q ? mem_rd_q : gmmwf_pkg::pick_ext(cfg_mode_q, acc_q, mem_rd_q);
    win_val  = col_ext_q[0];
    for (int i = 1; i < KERN; i++) begin
      if (SPAN_W'(i) <= span_q) win_val = gmmwf_pkg::pick_ext(cfg_mode_q, win_val, col_ext_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= pix_q;
    end else if (mem_re) begin
      mem_rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_width_q   <= DIM_W'(512);
      cfg_height_q  <= DIM_W'(512);
      cfg_wsize_q   <= WSZ_W'(3);
      cfg_mode_q    <= gmmwf_pkg::MODE_MAX;
      in_row_q      <= '0;
      in_col_q      <= '0;
      out_row_q     <= '0;
      out_col_q     <= '0;
      in_slot_q     <= '0;
      out_slot_q    <= '0;
      pix_q         <= '0;
      drain_q       <= 1'b0;
      total_q       <= '0;
      k_q           <= '0;
      lag_q         <= '0;
      due_q         <= 1'b0;
      last_q        <= 1'b0;
      rd_col_q      <= '0;
      rd_slot_q     <= '0;
      base_slot_q   <= '0;
      rd_row_q      <= '0;
      row_end_q     <= '0;
      cols_left_q   <= '0;
      span_q        <= '0;
      pend_q        <= 1'b0;
      pend_first_q  <= 1'b0;
      pend_colend_q <= 1'b0;
      acc_q         <= '0;
      for (int i = 0; i < KERN; i++) col_ext_q[i] <= '0;
      cache_ok_q    <= 1'b0;
      m_valid_q     <= 1'b0;
      m_last_q      <= 1'b0;
      m_data_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gmmwf_pkg::REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_wdata_i;
          gmmwf_pkg::REG_IMAGE_HEIGHT: cfg_height_q <= cfg_wdata_i;
          gmmwf_pkg::REG_WINDOW_SIZE:  cfg_wsize_q  <= cfg_wdata_i[WSZ_W-1:0];
          gmmwf_pkg::REG_FILTER_MODE:  cfg_mode_q   <= cfg_wdata_i[0];
          default: ;
        endcase
        cache_ok_q <= 1'b0;
      end

      // read data is registered and comes back in the cycle after the address
      pend_q        <= (state_q == S_RD);
      pend_first_q  <= (rd_row_q == '0);
      pend_colend_q <= (rd_row_q == row_end_q);
      if (pend_q) begin
        acc_q <= acc_next;
        if (pend_colend_q) begin
          for (int i = KERN - 1; i > 0; i--) col_ext_q[i] <= col_ext_q[i-1];
          col_ext_q[0] <= acc_next;
        end
      end

      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            pix_q   <= s_axis_tdata_i;
            drain_q <= s_axis_tuser_i;
            state_q <= S_TOT;
          end
        end
        S_TOT: begin
          total_q <= mul_p[POS_W-1:0];
          lag_q   <= lag_c;
          state_q <= S_KPOS;
        end
        S_KPOS: begin
          if (clr_pos) begin
            in_row_q   <= '0;
            in_col_q   <= '0;
            out_row_q  <= '0;
            out_col_q  <= '0;
            in_slot_q  <= '0;
            out_slot_q <= '0;
            cache_ok_q <= 1'b0;
          end
          k_q     <= mul_p[POS_W-1:0] + POS_W'(kpos_col);
          state_q <= S_CHK;
        end
        S_CHK: begin
          // frame wrapped or position out of reach: restart at the origin
          if (clr_frame) begin
            in_row_q   <= '0;
            in_col_q   <= '0;
            out_row_q  <= '0;
            out_col_q  <= '0;
            in_slot_q  <= '0;
            out_slot_q <= '0;
            cache_ok_q <= 1'b0;
          end
          due_q   <= (POS_W+1)'(k_eff) >= (POS_W+1)'(lag_q);
          state_q <= S_PLAN;
        end
        S_PLAN: begin
          if (!due_q || !last_c) begin
            if (in_col_nx >= (DIM_W+1)'(w_eff)) begin
              in_col_q  <= '0;
              in_row_q  <= in_row_q + DIM_W'(1);
              in_slot_q <= (in_slot_q == SLOT_W'(KERN - 1)) ? '0 : in_slot_q + SLOT_W'(1);
            end else begin
              in_col_q <= in_col_nx[DIM_W-1:0];
            end
          end
          if (!due_q) begin
            state_q <= S_IDLE;
          end else begin
            // full rebuild walks all window columns, otherwise one column
            if (inc_ok) rd_col_q <= COL_W'(out_col_q + DIM_W'(half));
            else if (interior) rd_col_q <= COL_W'(out_col_q - DIM_W'(half));
            else rd_col_q <= out_col_q[COL_W-1:0];
            rd_slot_q   <= interior ? top_slot[SLOT_W-1:0] : out_slot_q;
            base_slot_q <= interior ? top_slot[SLOT_W-1:0] : out_slot_q;
            rd_row_q    <= '0;
            row_end_q   <= interior ? span2h : '0;
            span_q      <= interior ? span2h : '0;
            cols_left_q <= (interior && !inc_ok) ? span2h : '0;
            last_q      <= last_c;
            cache_ok_q  <= interior && (out_col_nx < (DIM_W+1)'(w_eff));
            if (last_c) begin
              in_row_q   <= '0;
              in_col_q   <= '0;
              out_row_q  <= '0;
              out_col_q  <= '0;
              in_slot_q  <= '0;
              out_slot_q <= '0;
            end else if (out_col_nx >= (DIM_W+1)'(w_eff)) begin
              out_col_q  <= '0;
              out_row_q  <= out_row_q + DIM_W'(1);
              out_slot_q <= (out_slot_q == SLOT_W'(KERN - 1)) ? '0 : out_slot_q + SLOT_W'(1);
            end else begin
              out_col_q <= out_col_nx[DIM_W-1:0];
            end
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (rd_row_q == row_end_q) begin
            rd_row_q  <= '0;
            rd_slot_q <= base_slot_q;
            rd_col_q  <= rd_col_q + COL_W'(1);
            if (cols_left_q == '0) state_q <= S_WAIT;
            else cols_left_q <= cols_left_q - SPAN_W'(1);
          end else begin
            rd_row_q  <= rd_row_q + SPAN_W'(1);
            rd_slot_q <= (rd_slot_q == SLOT_W'(KERN - 1)) ? '0 : rd_slot_q + SLOT_W'(1);
          end
        end
        S_WAIT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= win_val;
            m_last_q  <= last_q;
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // read data is only consumed right after an issued read
  a_pend_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == S_RD))
    else $error("read data consumed without a read");

  // row slots stay inside the line store
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (rd_slot_q < SLOT_W'(KERN)) && (base_slot_q < SLOT_W'(KERN)))
    else $error("line store slot out of range");

  // the frame's last output returns every position to the origin
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN && due_q && last_c) |=>
      (in_row_q == '0) && (in_col_q == '0) && (out_row_q == '0) && (out_col_q == '0))
    else $error("positions not cleared at frame end");

endmodule
